/* rtl/ssrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrs_pkg: shared definitions of the span shift-reduce stack
// Sizes, status and command codes, and the layout of one stack entry.
// ----------------------------------------------------------------------------
package ssrs_pkg;

	localparam int STACK_DEPTH      = 64;
	localparam int POS_BITS         = 8;
	localparam int ADDR_BITS        = $clog2(STACK_DEPTH);
	localparam int SP_BITS          = $clog2(STACK_DEPTH + 1);
	// The running size sum stays well inside this width, so equality of the
	// wrapped values is the same as equality of the true values.
	localparam int SIZE_BITS        = POS_BITS + SP_BITS + 1;
	localparam int DEPTH_FIELD_BITS = 7;
	localparam int COUNT_BITS       = 32;
	localparam int STATUS_BITS      = 2;
	localparam int ENTRY_BITS       = 4 * POS_BITS;

	localparam logic [DEPTH_FIELD_BITS-1:0] DEPTH_FIELD_FULL = DEPTH_FIELD_BITS'(STACK_DEPTH);

	localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_OVERLAP = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_SHIFT = 1'b1;

	typedef logic [POS_BITS-1:0]   pos_t;
	typedef logic [SP_BITS-1:0]    sp_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [SIZE_BITS-1:0]  size_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		pos_t s;
		pos_t e;
		pos_t lb;
		pos_t rb;
	} span_entry_t;

endpackage

/* rtl/ssrs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrs_if: command and result channels of the span shift-reduce stack
// Valid/ready channels; one transfer moves one item.
// ----------------------------------------------------------------------------
interface ssrs_cmd_if;
	import ssrs_pkg::*;

	logic valid;
	logic ready;
	logic command;
	pos_t span_start;
	pos_t span_end;
	pos_t sentence_length;

	modport source (output valid, output command, output span_start, output span_end,
		output sentence_length, input ready);
	modport sink (input valid, input command, input span_start, input span_end,
		input sentence_length, output ready);
endinterface

interface ssrs_res_if;
	import ssrs_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [STATUS_BITS-1:0]      status;
	pos_t                        top_start;
	pos_t                        top_end;
	pos_t                        left_bound;
	pos_t                        right_bound;
	logic [DEPTH_FIELD_BITS-1:0] stack_depth;
	count_t                      non_itg_total;

	modport source (output valid, output status, output top_start, output top_end,
		output left_bound, output right_bound, output stack_depth, output non_itg_total,
		input ready);
	modport sink (input valid, input status, input top_start, input top_end,
		input left_bound, input right_bound, input stack_depth, input non_itg_total,
		output ready);
endinterface

/* rtl/ssrs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/span_shift_reduce_stack.sv */
`timescale 1ns / 1ps
// A start command or an ignored shift goes from the idle state straight to the finish state; a
// placed shift first walks the stack entries, from the top entry downward, in the walk state.
// The walk visits all entries down to the root when non-ITG merges are allowed, else it stops at
// the first entry that does not merge; it reads one entry per cycle from the stack RAM.
// The next command is taken once the result is loaded, and loading waits while a result waits.
// Reset clears depth to the root entry, the non-ITG count to zero and enables non-ITG merges.
// ----------------------------------------------------------------------------
// span_shift_reduce_stack: shift-reduce stack of source spans
// Places new spans beside the top span and greedily merges contiguous spans
// with one shared compare/add unit, walking the stack one entry per cycle.
// ----------------------------------------------------------------------------
module span_shift_reduce_stack (
	input  logic         clk,
	input  logic         arst_n,
	ssrs_cmd_if.sink     cmd,
	ssrs_res_if.source   res,
	input  logic         cfg_wen,
	input  logic         cfg_wdata
);
	import ssrs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]       state_q;
	sp_t              sp_q;
	span_entry_t      top_q;
	span_entry_t      cur_q;
	pos_t             imin_q;
	pos_t             imax_q;
	size_t            size_q;
	logic [1:0]       dep_q;
	addr_t            jd_q;
	addr_t            tidx_q;
	count_t           count_q;
	logic             allow_q;
	logic [STATUS_BITS-1:0] status_q;
	logic             wr_q;

	logic                        ov_q;
	logic [STATUS_BITS-1:0]      o_status_q;
	span_entry_t                 o_entry_q;
	logic [DEPTH_FIELD_BITS-1:0] o_depth_q;
	count_t                      o_total_q;

	logic        accept;
	logic        go_left;
	logic        go_right;
	logic        fin_load;
	addr_t       raddr;
	logic [ENTRY_BITS-1:0] rdata;
	span_entry_t rd_entry;

	pos_t        w_imin;
	pos_t        w_imax;
	size_t       w_size;
	logic [1:0]  w_dep;
	logic        w_merge;
	logic        w_more;

	assign accept   = cmd.valid && (state_q == ST_IDLE);
	assign go_left  = cmd.span_end <= top_q.s;
	assign go_right = cmd.span_start >= top_q.e;
	assign fin_load = (state_q == ST_FIN) && (!ov_q || res.ready);
	assign rd_entry = span_entry_t'(rdata);

	always_comb begin
		if (state_q == ST_IDLE) begin
			raddr = ADDR_BITS'(sp_q - SP_BITS'(1));
		end else begin
			raddr = jd_q - ADDR_BITS'(1);
		end
	end

	// Shared merge unit: extends the union with one stack entry and tests contiguity.
	always_comb begin
		w_imax  = (rd_entry.e > imax_q) ? rd_entry.e : imax_q;
		w_imin  = (rd_entry.s < imin_q) ? rd_entry.s : imin_q;
		w_size  = size_q + (SIZE_BITS'(rd_entry.e) - SIZE_BITS'(rd_entry.s));
		w_dep   = (dep_q == 2'd3) ? 2'd3 : dep_q + 2'd1;
		w_merge = w_size == (SIZE_BITS'(w_imax) - SIZE_BITS'(w_imin));
		w_more  = (jd_q != '0) && (allow_q || w_merge);
	end

	ssrs_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (fin_load && wr_q),
		.waddr (tidx_q),
		.wdata (cur_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sp_q    <= SP_BITS'(1);
			count_q <= '0;
			allow_q <= 1'b1;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				allow_q <= cfg_wdata;
			end
			if (fin_load) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.command == CMD_START) begin
							state_q  <= ST_FIN;
							status_q <= STATUS_OK;
							wr_q     <= 1'b1;
							tidx_q   <= '0;
							cur_q    <= '{s: '0, e: '0, lb: '0, rb: cmd.sentence_length};
						end else if (sp_q == SP_BITS'(STACK_DEPTH)) begin
							state_q  <= ST_FIN;
							status_q <= STATUS_FULL;
							wr_q     <= 1'b0;
						end else if (go_left == go_right) begin
							state_q  <= ST_FIN;
							status_q <= STATUS_OVERLAP;
							wr_q     <= 1'b0;
						end else begin
							state_q  <= ST_WALK;
							status_q <= STATUS_OK;
							wr_q     <= 1'b1;
							tidx_q   <= ADDR_BITS'(sp_q);
							jd_q     <= ADDR_BITS'(sp_q - SP_BITS'(1));
							imin_q   <= cmd.span_start;
							imax_q   <= cmd.span_end;
							size_q   <= SIZE_BITS'(cmd.span_end) - SIZE_BITS'(cmd.span_start);
							dep_q    <= 2'd1;
							cur_q.s  <= cmd.span_start;
							cur_q.e  <= cmd.span_end;
							if (go_left) begin
								cur_q.lb <= top_q.lb;
								cur_q.rb <= top_q.s;
							end else begin
								cur_q.lb <= top_q.e;
								cur_q.rb <= top_q.rb;
							end
						end
					end
				end
				ST_WALK: begin
					imin_q <= w_imin;
					imax_q <= w_imax;
					size_q <= w_size;
					if (w_merge) begin
						cur_q  <= '{s: w_imin, e: w_imax, lb: rd_entry.lb, rb: rd_entry.rb};
						tidx_q <= jd_q;
						dep_q  <= 2'd1;
						// A merge that covers more than two entries is not ITG.
						if (w_dep == 2'd3 && count_q != '1) begin
							count_q <= count_q + COUNT_BITS'(1);
						end
					end else begin
						dep_q <= w_dep;
					end
					if (w_more) begin
						jd_q <= jd_q - ADDR_BITS'(1);
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q    <= ST_IDLE;
						o_status_q <= status_q;
						o_total_q  <= count_q;
						if (wr_q) begin
							sp_q      <= SP_BITS'(tidx_q) + SP_BITS'(1);
							o_entry_q <= cur_q;
							o_depth_q <= DEPTH_FIELD_BITS'(SP_BITS'(tidx_q) + SP_BITS'(1));
						end else begin
							o_entry_q <= top_q;
							o_depth_q <= DEPTH_FIELD_BITS'(sp_q);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Copy of the top stack entry, so placement tests need no RAM read.
	always_ff @(posedge clk) begin
		if (fin_load && wr_q) begin
			top_q <= cur_q;
		end
	end

	assign cmd.ready         = state_q == ST_IDLE;
	assign res.valid         = ov_q;
	assign res.status        = o_status_q;
	assign res.top_start     = o_entry_q.s;
	assign res.top_end       = o_entry_q.e;
	assign res.left_bound    = o_entry_q.lb;
	assign res.right_bound   = o_entry_q.rb;
	assign res.stack_depth   = o_depth_q;
	assign res.non_itg_total = o_total_q;

endmodule

/* rtl/ssrs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrs_checker: port-level checks of the span shift-reduce stack
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module ssrs_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  res_valid,
	input logic                                  res_ready,
	input logic [ssrs_pkg::STATUS_BITS-1:0]      res_status,
	input ssrs_pkg::pos_t                        res_top_start,
	input ssrs_pkg::pos_t                        res_top_end,
	input ssrs_pkg::pos_t                        res_left_bound,
	input ssrs_pkg::pos_t                        res_right_bound,
	input logic [ssrs_pkg::DEPTH_FIELD_BITS-1:0] res_stack_depth,
	input ssrs_pkg::count_t                      res_non_itg_total
);
	import ssrs_pkg::*;

	logic [DEPTH_FIELD_BITS-1:0] last_depth_q;
	count_t                      last_total_q;
	logic                        res_xfer;

	assign res_xfer = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_depth_q <= DEPTH_FIELD_BITS'(1);
			last_total_q <= '0;
		end else if (res_xfer) begin
			last_depth_q <= res_stack_depth;
			last_total_q <= res_non_itg_total;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
		&& $stable(res_top_start) && $stable(res_top_end) && $stable(res_left_bound)
		&& $stable(res_right_bound) && $stable(res_stack_depth) && $stable(res_non_itg_total))
		else $error("result changed while stalled");

	// The non-ITG count saturates and survives a new sentence.
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer |-> res_non_itg_total >= last_total_q)
		else $error("non-ITG total went down");

	// An ignored shift leaves the stack as it was.
	a_ignored_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && res_status != STATUS_OK |-> res_stack_depth == last_depth_q)
		else $error("ignored shift changed the stack depth");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STATUS_FULL |-> res_stack_depth == DEPTH_FIELD_FULL)
		else $error("stack-full status with a stack that is not full");

endmodule

bind span_shift_reduce_stack ssrs_checker u_ssrs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_status        (res.status),
	.res_top_start     (res.top_start),
	.res_top_end       (res.top_end),
	.res_left_bound    (res.left_bound),
	.res_right_bound   (res.right_bound),
	.res_stack_depth   (res.stack_depth),
	.res_non_itg_total (res.non_itg_total)
);
